// ===== hw/rtl/awwf_pkg.sv =====
package awwf_pkg;

	localparam int MAX_WIDTH = 128;

	localparam logic [7:0] CHAR_HSPACE  = 8'h01;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	localparam logic [1:0] MODE_PRE    = 2'd0;
	localparam logic [1:0] MODE_LEFT   = 2'd1;
	localparam logic [1:0] MODE_CENTER = 2'd2;
	localparam logic [1:0] MODE_RIGHT  = 2'd3;

	localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;
	localparam logic       REG_LINE_WIDTH   = 1'b0;
	localparam logic [1:0] ADDR_LINE_WIDTH  = 2'(4 * REG_LINE_WIDTH);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RDPREV,
		ST_CHECK,
		ST_SCAN,
		ST_SCANWAIT,
		ST_PAD,
		ST_TEXT,
		ST_TEXTWAIT,
		ST_NL,
		ST_FLUSH,
		ST_MOVE,
		ST_MOVEWAIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture request
		logic rd_prev;    // read store at len-1
		logic append;     // write char at len, len++
		logic scan_rd;    // read store at scan index
		logic scan_dec;   // scan index--
		logic begin_emit; // set up pad/text counters for emit length
		logic emit_pad;   // push one space
		logic text_rd;    // read store at text index
		logic emit_text;  // push read byte
		logic emit_nl;    // push newline
		logic flush;      // send packed bytes as last chunk
		logic clr_len;    // line length = 0
		logic move_rd;    // read store at src index
		logic move_wr;    // write read byte at dst index
		logic move_done;  // line length = rest
		logic brk_full;   // emit whole line (no space found)
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic suppress;
		logic is_nl;
		logic drop;       // whitespace to be dropped
		logic need_break; // len >= width after append
		logic scan_ws;    // scanned byte is whitespace
		logic scan_zero;  // scan index is zero
		logic pad_left;
		logic text_left;
		logic nl_ok;
		logic move_left;
		logic out_busy;   // output register holds a chunk not yet taken
		logic out_empty;  // packer holds no bytes
	} stat_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

endpackage

// ===== hw/rtl/awwf_if.sv =====
interface awwf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic [1:0] align;
	logic       suppress;
	modport source (output valid, char_in, align, suppress, input ready);
	modport sink   (input valid, char_in, align, suppress, output ready);
endinterface

interface awwf_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] chunk;
	logic [3:0]  byte_count;
	logic        last_chunk;
	modport source (output valid, chunk, byte_count, last_chunk, input ready);
	modport sink   (input valid, chunk, byte_count, last_chunk, output ready);
endinterface

// ===== hw/rtl/awwf_ctrl.sv =====
module awwf_ctrl
	import awwf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_nx;
	logic   full_q;  // break without a space: no newline, clear line

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_IDLE) full_q <= 1'b0;
			else if (cmd.brk_full) full_q <= 1'b1;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && stat.out_empty) state_nx = ST_RDPREV;
			end
			ST_RDPREV: begin
				if (stat.suppress) state_nx = ST_IDLE;
				else if (stat.is_nl) state_nx = ST_PAD;
				else state_nx = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.drop) state_nx = ST_IDLE;
				else if (stat.need_break) state_nx = ST_SCAN;
				else state_nx = ST_IDLE;
			end
			ST_SCAN: state_nx = ST_SCANWAIT;
			ST_SCANWAIT: begin
				if (stat.scan_zero) state_nx = ST_PAD;
				else if (stat.scan_ws) state_nx = ST_PAD;
				else state_nx = ST_SCAN;
			end
			ST_PAD: begin
				if (!stat.out_busy && !stat.pad_left) state_nx = ST_TEXT;
			end
			ST_TEXT: begin
				if (!stat.out_busy) begin
					if (stat.text_left) state_nx = ST_TEXTWAIT;
					else state_nx = ST_NL;
				end
			end
			ST_TEXTWAIT: begin
				if (!stat.out_busy) state_nx = ST_TEXT;
			end
			ST_NL: begin
				if (!stat.out_busy) state_nx = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!stat.out_busy) state_nx = ST_MOVE;
			end
			ST_MOVE: begin
				if (stat.move_left) state_nx = ST_MOVEWAIT;
				else state_nx = ST_IDLE;
			end
			ST_MOVEWAIT: state_nx = ST_MOVE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = stat.out_empty;
				cmd.load = in_valid && stat.out_empty;
			end
			ST_RDPREV: cmd.rd_prev = 1'b1;
			ST_CHECK: begin
				cmd.append = !stat.drop;
				cmd.scan_rd = !stat.drop && stat.need_break;
			end
			ST_SCAN: cmd.scan_rd = 1'b1;
			ST_SCANWAIT: begin
				if (stat.scan_zero || stat.scan_ws) begin
					cmd.begin_emit = 1'b1;
					cmd.brk_full   = stat.scan_zero;
				end else begin
					cmd.scan_dec = 1'b1;
				end
			end
			ST_PAD: begin
				if (!stat.out_busy && stat.pad_left) cmd.emit_pad = 1'b1;
			end
			ST_TEXT: begin
				if (!stat.out_busy && stat.text_left) cmd.text_rd = 1'b1;
			end
			ST_TEXTWAIT: begin
				if (!stat.out_busy) cmd.emit_text = 1'b1;
			end
			ST_NL: begin
				if (!stat.out_busy && stat.nl_ok && !full_q) cmd.emit_nl = 1'b1;
			end
			ST_FLUSH: begin
				if (!stat.out_busy) begin
					cmd.flush = 1'b1;
					cmd.clr_len = full_q;
				end
			end
			ST_MOVE: begin
				if (stat.move_left) cmd.move_rd = 1'b1;
				else cmd.move_done = 1'b1;
			end
			ST_MOVEWAIT: cmd.move_wr = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/awwf_dp.sv =====
module awwf_dp
	import awwf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            char_in,
	input  logic [1:0]            align,
	input  logic                  suppress,
	input  logic [7:0]            line_width,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [63:0]           chunk,
	output logic [3:0]            byte_count,
	output logic                  last_chunk
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int LW = AW + 1;

	logic [7:0] mem [MAX_WIDTH];
	logic [7:0] rd_q;

	logic [7:0]    c_q;
	logic [1:0]    align_q;
	logic          sup_q;
	logic [LW-1:0] len_q;      // 0..MAX_WIDTH
	logic [LW-1:0] w_q;        // effective width 1..MAX_WIDTH
	logic [LW-1:0] idx_q;      // scan / text / move index
	logic [LW-1:0] n_q;        // emitted text length
	logic [LW-1:0] pad_q;
	logic [LW-1:0] dst_q;
	logic [LW-1:0] rest_q;

	logic [63:0] pk_q;
	logic [3:0]  pk_cnt_q;

	logic [LW-1:0] w_eff;
	always_comb begin
		if (line_width == 8'd0) w_eff = LW'(1);
		else if ({1'b0, line_width} > 9'(MAX_WIDTH)) w_eff = LW'(MAX_WIDTH);
		else w_eff = LW'(line_width);
	end

	// a single read port, address chosen by the command
	logic [AW-1:0] rd_addr;
	always_comb begin
		if (cmd.rd_prev) rd_addr = AW'(len_q - LW'(1));
		else if (cmd.scan_rd && len_q == LW'(0)) rd_addr = '0;
		else rd_addr = idx_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (cmd.append) mem[len_q[AW-1:0]] <= c_q;
		if (cmd.move_wr) mem[dst_q[AW-1:0]] <= rd_q;
	end

	logic [LW-1:0] len_inc;
	assign len_inc = len_q + LW'(1);

	logic push;
	logic [7:0] push_b;
	always_comb begin
		push = cmd.emit_pad || cmd.emit_text || cmd.emit_nl;
		if (cmd.emit_pad) push_b = CHAR_SPACE;
		else if (cmd.emit_nl) push_b = CHAR_NEWLINE;
		else if (rd_q == CHAR_HSPACE) push_b = CHAR_SPACE;
		else push_b = rd_q;
	end

	// emit setup: for a newline n = len, for a break n = idx (0 means whole line)
	logic [LW-1:0] n_sel;
	logic [LW-1:0] pad_sel;
	always_comb begin
		n_sel = c_q == CHAR_NEWLINE ? len_q : (idx_q == LW'(0) ? len_q : idx_q);
		pad_sel = '0;
		if (n_sel < w_q) begin
			if (align_q == MODE_CENTER) pad_sel = (w_q - n_sel) >> 1;
			else if (align_q == MODE_RIGHT) pad_sel = w_q - n_sel;
		end
	end

	// a full chunk is held in the packer until the next byte arrives, so the
	// flush always knows which chunk is the last one of the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			pk_q       <= '0;
			pk_cnt_q   <= '0;
			out_valid  <= 1'b0;
			chunk      <= '0;
			byte_count <= '0;
			last_chunk <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (cmd.load && len_q > LW'(MAX_WIDTH - 1)) len_q <= LW'(MAX_WIDTH - 1);
			if (cmd.append) len_q <= len_inc;
			if (cmd.clr_len) len_q <= '0;
			if (cmd.move_done && c_q != CHAR_NEWLINE && n_q != LW'(0)) len_q <= rest_q;
			if (cmd.move_done && c_q == CHAR_NEWLINE) len_q <= '0;
			if (push) begin
				if (pk_cnt_q == 4'd8) begin
					out_valid  <= 1'b1;
					chunk      <= pk_q;
					byte_count <= 4'd8;
					last_chunk <= 1'b0;
					pk_q[7:0]  <= push_b;
					pk_cnt_q   <= 4'd1;
				end else begin
					pk_q[pk_cnt_q[2:0]*8 +: 8] <= push_b;
					pk_cnt_q <= pk_cnt_q + 4'd1;
				end
			end
			if (cmd.flush) begin
				pk_cnt_q <= '0;
				if (pk_cnt_q != 4'd0) begin
					out_valid <= 1'b1;
					for (int j = 0; j < 8; j++)
						chunk[j*8 +: 8] <= (4'(j) < pk_cnt_q) ? pk_q[j*8 +: 8] : 8'h00;
					byte_count <= pk_cnt_q;
					last_chunk <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_q     <= char_in;
			align_q <= align;
			sup_q   <= suppress;
			w_q     <= w_eff;
		end
		if (cmd.append) idx_q <= len_q;
		if (cmd.scan_dec) idx_q <= idx_q - LW'(1);
		if (cmd.begin_emit || (cmd.load && char_in == CHAR_NEWLINE)) begin
			idx_q <= '0;
		end
		if (cmd.rd_prev && c_q == CHAR_NEWLINE) begin
			n_q   <= len_q;
			pad_q <= '0;
			if (len_q < w_q) begin
				if (align_q == MODE_CENTER) pad_q <= (w_q - len_q) >> 1;
				else if (align_q == MODE_RIGHT) pad_q <= w_q - len_q;
			end
			idx_q <= '0;
		end
		if (cmd.begin_emit) begin
			n_q    <= idx_q == LW'(0) ? len_q : idx_q;
			pad_q  <= pad_sel;
			rest_q <= idx_q == LW'(0) ? '0 : len_q - LW'(1) - idx_q;
			dst_q  <= '0;
			idx_q  <= '0;
		end
		if (cmd.emit_pad) pad_q <= pad_q - LW'(1);
		if (cmd.text_rd) idx_q <= idx_q + LW'(1);
		if (cmd.flush) begin
			idx_q <= n_q + LW'(1);
			dst_q <= '0;
		end
		if (cmd.move_rd) idx_q <= idx_q + LW'(1);
		if (cmd.move_wr) dst_q <= dst_q + LW'(1);
	end

	logic out_busy;
	assign out_busy = out_valid && !out_ready;

	always_comb begin
		stat.suppress   = sup_q;
		stat.is_nl      = c_q == CHAR_NEWLINE;
		stat.drop       = align_q != MODE_PRE && is_ws(c_q) &&
		                  (len_q == LW'(0) || is_ws(rd_q));
		stat.need_break = len_inc >= w_q;
		stat.scan_ws    = is_ws(rd_q);
		stat.scan_zero  = idx_q == LW'(0);
		stat.pad_left   = pad_q != LW'(0);
		stat.text_left  = idx_q < n_q;
		stat.nl_ok      = n_q < w_q;
		stat.move_left  = c_q != CHAR_NEWLINE && n_q != len_q && dst_q < rest_q;
		stat.out_busy   = out_busy;
		stat.out_empty  = pk_cnt_q == 4'd0;
	end

`ifndef SYNTHESIS
	ap_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_WIDTH)) else $error("line length out of range");
	ap_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pk_cnt_q <= 4'd8) else $error("packer count out of range");
	ap_push_hold: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !out_busy) else $error("push while output stalled");
`endif

endmodule

// ===== hw/rtl/aligned_word_wrap_formatter.sv =====
// Greedy word-wrap formatter: one character per request; kept characters go
// into a line store; lines are padded by alignment and packed into 8-byte
// chunks, the last chunk of a request marked by last_chunk. A newline emits
// the pad and the stored text. A line break scans the store back one entry
// at a time, then emits pad and text (text through the single store read
// port), then moves the carried remainder; scan and move span up to
// MAX_WIDTH entries when the width was lowered beneath a longer stored line.
// Output stalls hold the emitting steps. The next request is taken once the
// packer is empty, while the last chunk may still wait in the output register.
// Width register at address 0, 8 bits, reset 80; 0 acts as 1 and values above
// MAX_WIDTH act as MAX_WIDTH.
module aligned_word_wrap_formatter
	import awwf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	awwf_in_if.sink     in_ch,
	awwf_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] line_width_q;
	cmd_t  cmd;
	stat_t stat;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_LINE_WIDTH) ? {24'd0, line_width_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RESET;
		end else if (psel && penable && pwrite && paddr == ADDR_LINE_WIDTH) begin
			line_width_q <= pwdata[7:0];
		end
	end

	awwf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	awwf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (in_ch.char_in),
		.align      (in_ch.align),
		.suppress   (in_ch.suppress),
		.line_width (line_width_q),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.chunk      (out_ch.chunk),
		.byte_count (out_ch.byte_count),
		.last_chunk (out_ch.last_chunk)
	);

endmodule

// ===== bench/awwf_checker.sv =====
module awwf_checker
	import awwf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	awwf_in_if          in_ch,
	awwf_out_if         out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending
);

	localparam int StoreDepth = MAX_WIDTH;

	typedef struct {
		logic [63:0] chunk;
		logic [3:0]  byte_count;
		logic        last_chunk;
	} chunk_t;

	chunk_t      chunks_due[$];
	logic [7:0]  text_bytes[$];
	logic [7:0]  line_buf[StoreDepth];
	int          line_len;
	logic [7:0]  width_reg;

	function automatic bit blank(input logic [7:0] c);
		return c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// padding by alignment, then n stored bytes with hard spaces as spaces
	task automatic emit_line(input int n, input logic [1:0] al, input int w);
		int pad;
		pad = 0;
		if (n < w) begin
			if (al == MODE_CENTER)
				pad = (w - n) >> 1;
			else if (al == MODE_RIGHT)
				pad = w - n;
		end
		repeat (pad) text_bytes.push_back(CHAR_SPACE);
		for (int i = 0; i < n && i < StoreDepth; i++)
			text_bytes.push_back(line_buf[i] == CHAR_HSPACE ? CHAR_SPACE : line_buf[i]);
	endtask

	task automatic wrap_char(input logic [7:0] c, input logic [1:0] al, input logic sup);
		int w;
		int n;
		int rest;
		chunk_t ch;
		text_bytes.delete();
		if (!sup) begin
			w = width_reg;
			if (w > StoreDepth) w = StoreDepth;
			if (w < 1) w = 1;
			if (line_len > StoreDepth - 1) line_len = StoreDepth - 1;
			if (c == CHAR_NEWLINE) begin
				emit_line(line_len, al, w);
				if (line_len < w) text_bytes.push_back(CHAR_NEWLINE);
				line_len = 0;
			end else if (!(al != MODE_PRE && blank(c) &&
					(line_len == 0 || blank(line_buf[line_len-1])))) begin
				line_buf[line_len] = c;
				line_len++;
				if (line_len >= w) begin
					n = line_len - 1;
					while (n > 0 && !blank(line_buf[n])) n--;
					if (n > 0) begin
						rest = line_len - 1 - n;
						emit_line(n, al, w);
						if (n < w) text_bytes.push_back(CHAR_NEWLINE);
						for (int i = 0; i < rest; i++) line_buf[i] = line_buf[n+1+i];
						line_len = rest;
					end else begin
						emit_line(line_len, al, w);
						line_len = 0;
					end
				end
			end
		end
		// pack into 8-byte chunks
		while (text_bytes.size() > 0) begin
			ch.chunk = '0;
			ch.byte_count = '0;
			for (int j = 0; j < 8 && text_bytes.size() > 0; j++) begin
				ch.chunk[8*j +: 8] = text_bytes.pop_front();
				ch.byte_count++;
			end
			ch.last_chunk = text_bytes.size() == 0;
			chunks_due.push_back(ch);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		chunk_t e;
		if (!arst_n) begin
			line_len = 0;
			width_reg = LINE_WIDTH_RESET;
			chunks_due.delete();
			errors <= 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_LINE_WIDTH)
				width_reg = pwdata[7:0];
			if (out_ch.valid && out_ch.ready) begin
				if (chunks_due.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("unexpected chunk %h count %0d last %b",
							out_ch.chunk, out_ch.byte_count, out_ch.last_chunk);
				end else begin
					e = chunks_due.pop_front();
					if (e.chunk !== out_ch.chunk || e.byte_count !== out_ch.byte_count ||
							e.last_chunk !== out_ch.last_chunk) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("chunk mismatch: exp %h/%0d/%b got %h/%0d/%b",
								e.chunk, e.byte_count, e.last_chunk,
								out_ch.chunk, out_ch.byte_count, out_ch.last_chunk);
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				wrap_char(in_ch.char_in, in_ch.align, in_ch.suppress);
			pending = chunks_due.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
	import awwf_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          pending;

	// receiver control: a long hold-off counter plus random stall bursts
	int          hold_left = 0;
	int          stall_left = 0;
	bit          calm = 1'b0;   // no idling at all in the closing phase
	logic [1:0]  cur_align = MODE_LEFT;

	awwf_in_if  in_ch();
	awwf_out_if out_ch();

	always #5 clk = ~clk;

	aligned_word_wrap_formatter u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	awwf_checker u_chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
	);

	initial begin
		in_ch.valid = 1'b0;
		in_ch.char_in = '0;
		in_ch.align = '0;
		in_ch.suppress = 1'b0;
		out_ch.ready = 1'b0;
	end

	// one update of ready per edge, so no double assignment in a step
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if (!calm && arst_n && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 17);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// one request; an optional gap first, valid stays high back to back
	task automatic send_req(input logic [7:0] c, input logic [1:0] al, input logic sup);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.char_in <= c;
		in_ch.align <= al;
		in_ch.suppress <= sup;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	// wait for the checker to drain, then let any break in flight finish
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	task automatic write_width(input logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_LINE_WIDTH;
		pwdata <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// text-like stream: words, spaces, some newlines, some noise
	task automatic random_text(input int count);
		logic [7:0] c;
		int r;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 60)      c = 8'h61 + 8'($urandom_range(0, 25));
			else if (r < 78) c = CHAR_SPACE;
			else if (r < 82) c = CHAR_NEWLINE;
			else if (r < 86) c = 8'($urandom_range(9, 13));
			else if (r < 89) c = CHAR_HSPACE;
			else             c = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 19) == 0) cur_align = 2'($urandom_range(0, 3));
			send_req(c, cur_align, $urandom_range(0, 19) == 0);
		end
	endtask

	initial begin
		logic [7:0] widths[8] = '{8'd2, 8'd0, 8'd255, 8'd17, 8'd1, 8'd128, 8'd40, 8'd80};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset width 80
		send_req(CHAR_SPACE, MODE_LEFT, 1'b0);     // leading blank dropped
		send_req(8'h48, MODE_LEFT, 1'b0);
		send_req(CHAR_SPACE, MODE_LEFT, 1'b0);
		send_req(8'h09, MODE_LEFT, 1'b0);          // collapsed into the space
		send_req(CHAR_HSPACE, MODE_LEFT, 1'b0);    // hard space kept
		send_req(8'h00, MODE_LEFT, 1'b0);          // zero byte is plain text
		send_req(8'hFF, MODE_LEFT, 1'b0);
		send_req(CHAR_NEWLINE, MODE_CENTER, 1'b1); // suppressed newline: no effect
		send_req(CHAR_NEWLINE, MODE_CENTER, 1'b0);
		send_req(8'h7E, MODE_RIGHT, 1'b0);
		send_req(CHAR_NEWLINE, MODE_RIGHT, 1'b0);
		send_req(CHAR_SPACE, MODE_PRE, 1'b0);      // preformatted keeps blanks
		send_req(CHAR_SPACE, MODE_PRE, 1'b0);
		send_req(8'h0D, MODE_PRE, 1'b0);
		send_req(8'h80, MODE_PRE, 1'b0);
		send_req(CHAR_NEWLINE, MODE_PRE, 1'b0);
		send_req(CHAR_NEWLINE, MODE_LEFT, 1'b0);   // empty line
		send_req(8'h41, MODE_LEFT, 1'b0);
		send_req(8'h0B, MODE_LEFT, 1'b0);
		send_req(8'h42, MODE_LEFT, 1'b0);          // line carried into next phase
		settle();

		// width phases; the line is not flushed, so a smaller width may
		// meet a longer line and break on the next stored character
		foreach (widths[i]) begin
			write_width(widths[i]);
			if (i == 7) calm = 1'b1;
			if (i == 3) hold_left <= 3000;  // block fills up and stalls input
			random_text(widths[i] == 8'd128 || widths[i] == 8'd255 ? 30 : 15);
			settle();
		end

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#50000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/awwf_pkg.sv
hw/rtl/awwf_if.sv
hw/rtl/awwf_ctrl.sv
hw/rtl/awwf_dp.sv
hw/rtl/aligned_word_wrap_formatter.sv
bench/awwf_checker.sv
bench/tb_top.sv
